// ----- rtl/core/mca_pkg.sv -----
// mca_pkg: shared types, codes and constants of the moving or cumulative average block
// used by mca_div and moving_or_cumulative_average16; no dependencies
package mca_pkg;

	localparam int DATA_W           = 16;
	localparam int ACC_W            = 32;
	localparam int CFG_SIZE_W       = 7;
	localparam int CFG_DATA_W       = 7;
	localparam int WINDOW_DEPTH_DEF = 64;

	localparam logic [CFG_SIZE_W-1:0] RESET_SIZE = CFG_SIZE_W'(16);

	localparam logic CFG_IDX_MODE = 1'b0;
	localparam logic CFG_IDX_SIZE = 1'b1;

	localparam logic OP_PUT   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic MODE_WINDOWED  = 1'b0;
	localparam logic MODE_CUMULATIVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SUB,
		ST_DIV,
		ST_WAIT,
		ST_DONE
	} mca_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mca_div_stat_t;

	function automatic logic [DATA_W-1:0] sat_avg(input logic [ACC_W-1:0] q);
		logic [DATA_W-1:0] r;
		if (|q[ACC_W-1:DATA_W]) begin
			r = '1;
		end else begin
			r = q[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/mca_div.sv -----
// mca_div: bit-serial restoring divider, one quotient bit per cycle
// depends on mca_pkg for the status struct
module mca_div
	import mca_pkg::*;
#(
	parameter int W = ACC_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	output logic [W-1:0]  quotient,
	output mca_div_stat_t stat
);

	localparam int CntW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    dvs_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [W:0]      shifted;
	logic [W:0]      trial;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/core/moving_or_cumulative_average16.sv -----
// moving_or_cumulative_average16: windowed or cumulative average of 16-bit samples
// depends on mca_pkg and mca_div
//
// usage: an input transaction (in_valid high, in_stall low) carries operation and
// sample; each one yields exactly one output transaction carrying average.
// operation put adds the sample; operation clear zeroes position, count, sum and
// the last average and returns 0. the mode register picks windowed (ring of the last
// window-size samples, up to WINDOW_DEPTH) or cumulative averaging.
// configuration: cfg_we writes cfg_data into register cfg_index (0 mode, 1 size)
// at the clock edge; write only while no transaction is in flight.
// sequence: a put goes through memory read, sum update (and, when the window is
// full, subtract of the oldest sample), the bit-serial divider and handoff to the
// output register; a clear or a cumulative overflow skips the divider. one item is
// in flight at a time: a new one is taken only after the last one is handed off.
// the output register holds a result while out_stall is high; the next item is
// accepted meanwhile and waits at its end until the register frees.
// reset: asynchronous, active low; mode cumulative, window size 16, state zero.
module moving_or_cumulative_average16
	import mca_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [DATA_W-1:0]     sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_W-1:0]     average
);

	localparam int PtrW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SizeW = (PtrW + 1 > CFG_SIZE_W) ? PtrW + 1 : CFG_SIZE_W;
	localparam logic [SizeW-1:0] DepthV = SizeW'(WINDOW_DEPTH);

	mca_state_t state_q, state_nx;

	logic                  mode_q;
	logic [CFG_SIZE_W-1:0] size_cfg_q;
	logic [PtrW-1:0]       pos_q;
	logic [ACC_W-1:0]      cnt_q;
	logic [ACC_W-1:0]      sum_q;
	logic [DATA_W-1:0]     last_avg_q;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     out_avg_q;
	logic                  op_q;
	logic [DATA_W-1:0]     sample_q;
	logic [PtrW-1:0]       wpos_q;
	logic [DATA_W-1:0]     oldest_q;
	logic [DATA_W-1:0]     res_q;
	logic [DATA_W-1:0]     mem [WINDOW_DEPTH];

	logic [SizeW-1:0]  size_ext;
	logic [SizeW-1:0]  eff_size;
	logic [PtrW-1:0]   pos_eff;
	logic [SizeW-1:0]  pos_inc;
	logic [PtrW-1:0]   pos_next;
	logic              full;
	logic [ACC_W:0]    cum_sum;
	logic              cum_skip;
	logic              accept;
	logic              load_out;
	logic              div_start;
	logic              mem_we;
	logic [ACC_W-1:0]  quotient;
	mca_div_stat_t     div_stat;

	assign size_ext = SizeW'(size_cfg_q);

	always_comb begin
		eff_size = size_ext;
		if (size_ext == '0) begin
			eff_size = SizeW'(1);
		end
		if (eff_size > DepthV) begin
			eff_size = DepthV;
		end
	end

	assign pos_eff  = (SizeW'(pos_q) >= eff_size) ? '0 : pos_q;
	assign pos_inc  = SizeW'(wpos_q) + SizeW'(1);
	assign pos_next = (pos_inc >= eff_size) ? '0 : pos_inc[PtrW-1:0];
	assign full     = cnt_q >= ACC_W'(eff_size);
	assign cum_sum  = {1'b0, sum_q} + {{(ACC_W + 1 - DATA_W){1'b0}}, sample_q};
	assign cum_skip = cum_sum[ACC_W] || (&cnt_q);
	assign accept   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (op_q == OP_CLEAR) begin
					state_nx = ST_DONE;
				end else if (mode_q == MODE_WINDOWED) begin
					state_nx = full ? ST_SUB : ST_DIV;
				end else begin
					state_nx = cum_skip ? ST_DONE : ST_DIV;
				end
			end
			ST_SUB:  state_nx = ST_DIV;
			ST_DIV:  state_nx = ST_WAIT;
			ST_WAIT: begin
				if (div_stat.done) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		load_out  = 1'b0;
		mem_we    = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_UPDATE: mem_we = (op_q == OP_PUT) && (mode_q == MODE_WINDOWED);
			ST_DIV:    div_start = 1'b1;
			ST_DONE:   load_out = !out_valid_q || !out_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_CUMULATIVE;
			size_cfg_q <= RESET_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_MODE: mode_q     <= cfg_data[0];
				CFG_IDX_SIZE: size_cfg_q <= cfg_data[CFG_SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			last_avg_q <= '0;
		end else begin
			unique case (state_q)
				ST_UPDATE: begin
					if (op_q == OP_CLEAR) begin
						pos_q      <= '0;
						cnt_q      <= '0;
						sum_q      <= '0;
						last_avg_q <= '0;
					end else if (mode_q == MODE_WINDOWED) begin
						pos_q <= pos_next;
						sum_q <= sum_q + ACC_W'(sample_q);
						if (!full) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (!cum_skip) begin
						sum_q <= cum_sum[ACC_W-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SUB:  sum_q <= sum_q - ACC_W'(oldest_q);
				ST_WAIT: begin
					if (div_stat.done) begin
						last_avg_q <= (cnt_q == '0) ? '0 : sat_avg(quotient);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			sample_q <= sample;
			wpos_q   <= pos_eff;
		end
		if (state_q == ST_UPDATE) begin
			res_q <= (op_q == OP_CLEAR) ? '0 : last_avg_q;
		end else if (state_q == ST_WAIT && div_stat.done) begin
			res_q <= (cnt_q == '0) ? '0 : sat_avg(quotient);
		end
	end

	// window ring
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wpos_q] <= sample_q;
		end
		if (accept) begin
			oldest_q <= mem[pos_eff];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_avg_q <= res_q;
		end
	end

	mca_div #(
		.W(ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	assign out_valid = out_valid_q;
	assign average   = out_avg_q;

`ifndef ASSERT_OFF
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_WAIT)
		else $error("divider finished outside wait state");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		SizeW'(pos_q) < DepthV)
		else $error("write position beyond ring depth");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && op_q == OP_CLEAR) |=>
		(sum_q == '0 && cnt_q == '0 && last_avg_q == '0))
		else $error("clear left state behind");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && out_avg_q == $past(res_q))
		else $error("result not placed in output register");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");
`endif

endmodule
